[design/aff_pkg.sv]
// Shared widths, types and helper functions of the affine matrix inverter.
package aff_pkg;

	localparam int COEF_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int LANES      = 6;

	// Magnitude of a product or of a difference of two products.
	localparam int PROD_W = 2 * COEF_WIDTH;
	// Linear numerator: coefficient magnitude scaled by 2^(2F).
	localparam int LIN_W  = COEF_WIDTH + 2 * FRAC_BITS;
	// Translation numerator: product difference scaled by 2^F.
	localparam int TRN_W  = PROD_W + FRAC_BITS;
	localparam int NUM_W  = (LIN_W > TRN_W) ? LIN_W : TRN_W;
	// Quotient bits kept; anything at or above 2^QW saturates.
	localparam int QW     = COEF_WIDTH;
	localparam int CMP_W  = ((PROD_W + QW > NUM_W) ? PROD_W + QW : NUM_W) + 1;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef logic        [COEF_WIDTH-1:0] cmag_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [PROD_W:0]       wsum_t;
	typedef logic        [PROD_W-1:0]     den_t;
	typedef logic        [NUM_W-1:0]      num_t;
	typedef logic        [QW-1:0]         quo_t;

	typedef num_t  num_vec_t  [LANES];
	typedef coef_t coef_vec_t [LANES];

	typedef struct packed {
		logic singular;
		logic overflow;
	} flags_t;

	localparam coef_t COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
	localparam coef_t COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

	// Magnitude of a two's complement coefficient; the most negative value maps to 2^(W-1).
	function automatic cmag_t coef_mag(input coef_t x);
		cmag_t r;
		r = x[COEF_WIDTH-1] ? cmag_t'(~x + 1'b1) : cmag_t'(x);
		return r;
	endfunction

	// Magnitude of a difference of two products; it always fits PROD_W bits.
	function automatic den_t wide_mag(input wsum_t x);
		logic [PROD_W:0] t;
		t = x[PROD_W] ? (~x + 1'b1) : x;
		return t[PROD_W-1:0];
	endfunction

endpackage

[design/affine_2d_matrix_invert.sv]
// Top level of the pipelined inverter for 2D affine matrices in signed fixed point.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------------
//  in      | in_valid, in_ready  | coef_a coef_b coef_c coef_d shift_x shift_y
//  out     | out_valid, out_ready| inv_a inv_b inv_c inv_d inv_shift_x inv_shift_y
//          |                     | singular overflow
//
// One transaction enters per cycle while the output is not stalled. Its result passes through
// the capture, product and difference registers, the sign and magnitude split, the
// bit-per-stage divider and the output register.
// Reset clears only the valid bits of the pipeline; no result is pending after it.
// When the output register holds a result that is not taken, the whole pipeline holds and
// in_ready is low; nothing is lost or repeated. Bubbles between transactions are kept.
module affine_2d_matrix_invert (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  aff_pkg::coef_t coef_a,
	input  aff_pkg::coef_t coef_b,
	input  aff_pkg::coef_t coef_c,
	input  aff_pkg::coef_t coef_d,
	input  aff_pkg::coef_t shift_x,
	input  aff_pkg::coef_t shift_y,
	output logic           out_valid,
	input  logic           out_ready,
	output aff_pkg::coef_t inv_a,
	output aff_pkg::coef_t inv_b,
	output aff_pkg::coef_t inv_c,
	output aff_pkg::coef_t inv_d,
	output aff_pkg::coef_t inv_shift_x,
	output aff_pkg::coef_t inv_shift_y,
	output logic           singular,
	output logic           overflow
);
	import aff_pkg::*;

	// The pipeline advances as a whole whenever the output register is free or being emptied.
	logic en;

	logic             valid_s3, valid_s4, singular_s4;
	wsum_t            det_s3, nx_s3, ny_s3;
	coef_t            a_s3, b_s3, c_s3, d_s3;
	den_t             den_s4;
	num_vec_t         num_s4;
	logic [LANES-1:0] neg_s4;
	coef_vec_t        res_q;
	flags_t           flags_q;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Capture, the six products and the determinant and translation differences.
	aff_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.coef_a   (coef_a),
		.coef_b   (coef_b),
		.coef_c   (coef_c),
		.coef_d   (coef_d),
		.shift_x  (shift_x),
		.shift_y  (shift_y),
		.valid_s3 (valid_s3),
		.det_s3   (det_s3),
		.nx_s3    (nx_s3),
		.ny_s3    (ny_s3),
		.a_s3     (a_s3),
		.b_s3     (b_s3),
		.c_s3     (c_s3),
		.d_s3     (d_s3)
	);

	// Numerators and determinant become magnitudes, with the quotient signs beside them.
	aff_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_s3    (valid_s3),
		.det_s3      (det_s3),
		.nx_s3       (nx_s3),
		.ny_s3       (ny_s3),
		.a_s3        (a_s3),
		.b_s3        (b_s3),
		.c_s3        (c_s3),
		.d_s3        (d_s3),
		.valid_s4    (valid_s4),
		.singular_s4 (singular_s4),
		.den_s4      (den_s4),
		.num_s4      (num_s4),
		.neg_s4      (neg_s4)
	);

	// All six quotients share one denominator, so they travel as lanes of one divider.
	aff_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (valid_s4),
		.in_singular (singular_s4),
		.den         (den_s4),
		.num         (num_s4),
		.neg         (neg_s4),
		.out_valid   (out_valid),
		.res_q       (res_q),
		.flags_q     (flags_q)
	);

	assign inv_a       = res_q[0];
	assign inv_b       = res_q[1];
	assign inv_c       = res_q[2];
	assign inv_d       = res_q[3];
	assign inv_shift_x = res_q[4];
	assign inv_shift_y = res_q[5];
	assign singular    = flags_q.singular;
	assign overflow    = flags_q.overflow;

	// A singular matrix gives an all-zero result with no overflow.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> inv_a == '0 && inv_b == '0 && inv_c == '0 &&
			inv_d == '0 && inv_shift_x == '0 && inv_shift_y == '0 && !overflow)
		else $error("singular result carries nonzero fields");

	// Overflow means at least one field sits at a saturation limit.
	a_overflow_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
			inv_a == COEF_MAX || inv_a == COEF_MIN || inv_b == COEF_MAX ||
			inv_b == COEF_MIN || inv_c == COEF_MAX || inv_c == COEF_MIN ||
			inv_d == COEF_MAX || inv_d == COEF_MIN ||
			inv_shift_x == COEF_MAX || inv_shift_x == COEF_MIN ||
			inv_shift_y == COEF_MAX || inv_shift_y == COEF_MIN)
		else $error("overflow flagged without a saturated field");

	// A stalled pipeline keeps its pending result.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("pending result lost during stall");

endmodule

[design/aff_front.sv]
// Input capture, the six products and the three product differences.
module aff_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  aff_pkg::coef_t    coef_a,
	input  aff_pkg::coef_t    coef_b,
	input  aff_pkg::coef_t    coef_c,
	input  aff_pkg::coef_t    coef_d,
	input  aff_pkg::coef_t    shift_x,
	input  aff_pkg::coef_t    shift_y,
	output logic              valid_s3,
	output aff_pkg::wsum_t    det_s3,
	output aff_pkg::wsum_t    nx_s3,
	output aff_pkg::wsum_t    ny_s3,
	output aff_pkg::coef_t    a_s3,
	output aff_pkg::coef_t    b_s3,
	output aff_pkg::coef_t    c_s3,
	output aff_pkg::coef_t    d_s3
);
	import aff_pkg::*;

	logic  valid_s1, valid_s2;
	coef_t a_s1, b_s1, c_s1, d_s1, tx_s1, ty_s1;
	coef_t a_s2, b_s2, c_s2, d_s2;
	prod_t ad_s2, bc_s2, bty_s2, dtx_s2, ctx_s2, aty_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_a;
			b_s1  <= coef_b;
			c_s1  <= coef_c;
			d_s1  <= coef_d;
			tx_s1 <= shift_x;
			ty_s1 <= shift_y;

			ad_s2  <= prod_t'(a_s1) * prod_t'(d_s1);
			bc_s2  <= prod_t'(b_s1) * prod_t'(c_s1);
			bty_s2 <= prod_t'(b_s1) * prod_t'(ty_s1);
			dtx_s2 <= prod_t'(d_s1) * prod_t'(tx_s1);
			ctx_s2 <= prod_t'(c_s1) * prod_t'(tx_s1);
			aty_s2 <= prod_t'(a_s1) * prod_t'(ty_s1);
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			c_s2   <= c_s1;
			d_s2   <= d_s1;

			det_s3 <= wsum_t'(ad_s2) - wsum_t'(bc_s2);
			nx_s3  <= wsum_t'(bty_s2) - wsum_t'(dtx_s2);
			ny_s3  <= wsum_t'(ctx_s2) - wsum_t'(aty_s2);
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			c_s3   <= c_s2;
			d_s3   <= d_s2;
		end
	end

endmodule

[design/aff_prep.sv]
// Sign and magnitude split of the six numerators and of the determinant.
module aff_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_s3,
	input  aff_pkg::wsum_t    det_s3,
	input  aff_pkg::wsum_t    nx_s3,
	input  aff_pkg::wsum_t    ny_s3,
	input  aff_pkg::coef_t    a_s3,
	input  aff_pkg::coef_t    b_s3,
	input  aff_pkg::coef_t    c_s3,
	input  aff_pkg::coef_t    d_s3,
	output logic              valid_s4,
	output logic              singular_s4,
	output aff_pkg::den_t     den_s4,
	output aff_pkg::num_vec_t num_s4,
	output logic [aff_pkg::LANES-1:0] neg_s4
);
	import aff_pkg::*;

	num_t             num_c [LANES];
	logic [LANES-1:0] sgn_c;
	logic             dsgn;

	always_comb begin
		dsgn     = det_s3[PROD_W];
		num_c[0] = num_t'(coef_mag(d_s3)) << (2 * FRAC_BITS);
		num_c[1] = num_t'(coef_mag(b_s3)) << (2 * FRAC_BITS);
		num_c[2] = num_t'(coef_mag(c_s3)) << (2 * FRAC_BITS);
		num_c[3] = num_t'(coef_mag(a_s3)) << (2 * FRAC_BITS);
		num_c[4] = num_t'(wide_mag(nx_s3)) << FRAC_BITS;
		num_c[5] = num_t'(wide_mag(ny_s3)) << FRAC_BITS;
		sgn_c[0] = d_s3[COEF_WIDTH-1];
		sgn_c[1] = ~b_s3[COEF_WIDTH-1];
		sgn_c[2] = ~c_s3[COEF_WIDTH-1];
		sgn_c[3] = a_s3[COEF_WIDTH-1];
		sgn_c[4] = nx_s3[PROD_W];
		sgn_c[5] = ny_s3[PROD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			singular_s4 <= (det_s3 == '0);
			den_s4      <= wide_mag(det_s3);
			num_s4      <= num_c;
			neg_s4      <= sgn_c ^ {LANES{dsgn}};
		end
	end

endmodule

[design/aff_div.sv]
// Six-lane restoring divider, one quotient bit per stage, then round and saturate.
module aff_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic              in_singular,
	input  aff_pkg::den_t     den,
	input  aff_pkg::num_vec_t num,
	input  logic [aff_pkg::LANES-1:0] neg,
	output logic              out_valid,
	output aff_pkg::coef_vec_t res_q,
	output aff_pkg::flags_t   flags_q
);
	import aff_pkg::*;

	localparam int NST = QW + 2;

	logic             vld_s [NST];
	logic             sng_s [NST];
	den_t             den_s [NST];
	logic [LANES-1:0] neg_s [NST];
	logic [LANES-1:0] big_s [NST];
	num_t             rem_s [NST][LANES];
	quo_t             quo_s [NST][LANES];

	always_comb begin
		vld_s[0] = in_valid;
		sng_s[0] = in_singular;
		den_s[0] = den;
		neg_s[0] = neg;
		big_s[0] = '0;
		for (int l = 0; l < LANES; l++) begin
			rem_s[0][l] = num[l];
			quo_s[0][l] = '0;
		end
	end

	for (genvar j = 0; j <= QW; j++) begin : g_stage
		localparam int BIT = QW - j;
		logic [CMP_W-1:0] dsh;
		logic [LANES-1:0] ge;
		num_t             rem_n [LANES];
		quo_t             quo_n [LANES];
		logic [LANES-1:0] big_n;

		always_comb begin
			dsh = CMP_W'(den_s[j]) << BIT;
			for (int l = 0; l < LANES; l++) begin
				ge[l]    = CMP_W'(rem_s[j][l]) >= dsh;
				rem_n[l] = rem_s[j][l];
				quo_n[l] = quo_s[j][l];
				big_n[l] = big_s[j][l];
				if (BIT == QW) begin
					// Quotient at or above 2^QW: the lane saturates whatever follows.
					big_n[l] = ge[l];
				end else if (ge[l]) begin
					rem_n[l] = rem_s[j][l] - dsh[NUM_W-1:0];
					quo_n[l] = quo_s[j][l] | (quo_t'(1) << BIT);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sng_s[j+1] <= sng_s[j];
				den_s[j+1] <= den_s[j];
				neg_s[j+1] <= neg_s[j];
				big_s[j+1] <= big_n;
				rem_s[j+1] <= rem_n;
				quo_s[j+1] <= quo_n;
			end
		end
	end

	coef_vec_t       res_c;
	logic [LANES-1:0] ovf_c;

	always_comb begin
		logic        rnd;
		logic [QW:0] qr;
		logic [QW:0] lim;
		logic [QW:0] mag;
		for (int l = 0; l < LANES; l++) begin
			rnd = ({rem_s[NST-1][l], 1'b0}) >= (NUM_W+1)'(den_s[NST-1]);
			qr  = {1'b0, quo_s[NST-1][l]} + (QW+1)'(rnd);
			lim = neg_s[NST-1][l] ? ((QW+1)'(1) << (QW - 1))
			                      : (((QW+1)'(1) << (QW - 1)) - 1'b1);
			ovf_c[l] = big_s[NST-1][l] || (qr > lim);
			mag      = ovf_c[l] ? lim : qr;
			if (neg_s[NST-1][l]) begin
				mag = ~mag + 1'b1;
			end
			res_c[l] = sng_s[NST-1] ? '0 : coef_t'(mag[COEF_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q            <= res_c;
			flags_q.singular <= sng_s[NST-1];
			flags_q.overflow <= !sng_s[NST-1] && (|ovf_c);
		end
	end

endmodule

[test/affine_2d_matrix_invert_tb.sv]
// Self-checking testbench for the affine matrix inverter: directed corners, then random matrices.
module affine_2d_matrix_invert_tb;
	import aff_pkg::*;

	// One expected inverse, with both flags.
	typedef struct {
		logic signed [COEF_WIDTH-1:0] fld [6];
		logic                         sing;
		logic                         ovf;
	} inverse_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	coef_t coef_a, coef_b, coef_c, coef_d, shift_x, shift_y;
	logic out_valid;
	logic out_ready;
	coef_t inv_a, inv_b, inv_c, inv_d, inv_shift_x, inv_shift_y;
	logic singular;
	logic overflow;

	inverse_t pending_inverses[$];
	int       mismatch_count;
	int       matrices_sent;
	int       inverses_seen;
	int       singular_seen;
	int       overflow_seen;
	longint   cycle_count;

	localparam longint CYCLE_LIMIT = 400000;

	affine_2d_matrix_invert DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c), .coef_d(coef_d),
		.shift_x(shift_x), .shift_y(shift_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.inv_a(inv_a), .inv_b(inv_b), .inv_c(inv_c), .inv_d(inv_d),
		.inv_shift_x(inv_shift_x), .inv_shift_y(inv_shift_y),
		.singular(singular), .overflow(overflow)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Rounded, saturated quotient of two exact signed integers. Rounding is to nearest with
	// ties away from zero, done on magnitudes so that the sign never biases it.
	function automatic logic signed [COEF_WIDTH-1:0] rounded_quotient(
		input logic signed [255:0] num, input logic signed [255:0] den, inout logic ovf);
		logic [255:0] nmag, dmag, q, r;
		logic         neg;
		logic [255:0] lim;
		nmag = num[255] ? -num : num;
		dmag = den[255] ? -den : den;
		neg = num[255] ^ den[255];
		q = nmag / dmag;
		r = nmag % dmag;
		if ((r << 1) >= dmag)
			q = q + 1;
		lim = neg ? (256'd1 << (COEF_WIDTH - 1)) : (256'd1 << (COEF_WIDTH - 1)) - 1;
		if (q > lim) begin
			q = lim;
			ovf = 1'b1;
		end
		return neg ? -q[COEF_WIDTH-1:0] : q[COEF_WIDTH-1:0];
	endfunction

	// Works out the inverse of one matrix from exact integer products.
	function automatic inverse_t invert_matrix(input coef_t a, b, c, d, tx, ty);
		inverse_t res;
		logic signed [255:0] sa, sb, sc, sd, stx, sty, det, lin_scale, trn_scale;
		logic ovf;
		sa = a; sb = b; sc = c; sd = d; stx = tx; sty = ty;
		det = sa * sd - sb * sc;
		ovf = 1'b0;
		res.sing = 1'b0;
		foreach (res.fld[k])
			res.fld[k] = '0;
		if (det == 0) begin
			res.sing = 1'b1;
			res.ovf = 1'b0;
			return res;
		end
		lin_scale = 256'sd1 << (2 * FRAC_BITS);
		trn_scale = 256'sd1 << FRAC_BITS;
		res.fld[0] = rounded_quotient(sd * lin_scale, det, ovf);
		res.fld[1] = rounded_quotient(-sb * lin_scale, det, ovf);
		res.fld[2] = rounded_quotient(-sc * lin_scale, det, ovf);
		res.fld[3] = rounded_quotient(sa * lin_scale, det, ovf);
		res.fld[4] = rounded_quotient((sb * sty - sd * stx) * trn_scale, det, ovf);
		res.fld[5] = rounded_quotient((sc * stx - sa * sty) * trn_scale, det, ovf);
		res.ovf = ovf;
		return res;
	endfunction

	// Sends one matrix after a random gap, holding it until the block takes it.
	task automatic send_matrix(input coef_t a, b, c, d, tx, ty);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coef_a <= a; coef_b <= b; coef_c <= c; coef_d <= d;
		shift_x <= tx; shift_y <= ty;
		pending_inverses.push_back(invert_matrix(a, b, c, d, tx, ty));
		do
			@(posedge clk);
		while (!in_ready);
		matrices_sent++;
	endtask

	function automatic coef_t random_coef();
		case ($urandom_range(0, 5))
			0: return coef_t'($urandom);
			1: return coef_t'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
			2: return COEF_MIN;
			3: return COEF_MAX;
			4: return coef_t'($signed($urandom_range(0, 64)) - 32);
			default: return coef_t'($signed($urandom_range(0, 32'h100_0000)) - 32'sh80_0000);
		endcase
	endfunction

	// Corners: identity, extremes, singular matrices, exact tie cases and overflow.
	task automatic test_directed();
		coef_t one;
		one = coef_t'(1 << FRAC_BITS);
		send_matrix(one, 0, 0, one, 0, 0);
		send_matrix(one, 0, 0, one, COEF_MAX, COEF_MIN);
		send_matrix(0, 0, 0, 0, 0, 0);
		send_matrix(one, one, one, one, 5, 7);
		send_matrix(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
		send_matrix(COEF_MAX, 0, 0, COEF_MAX, COEF_MIN, COEF_MAX);
		send_matrix(COEF_MIN, 0, 0, COEF_MIN, COEF_MIN, COEF_MIN);
		send_matrix(COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN, -1, 1);
		send_matrix(1, 0, 0, 1, 1, -1);
		send_matrix(-1, 0, 0, -1, COEF_MAX, COEF_MAX);
		send_matrix(2 * one, 0, 0, 2 * one, 3, 3);
		send_matrix(3 * one, 0, 0, 3 * one, -1, 1);
		send_matrix(0, one, -one, 0, one, -one);
		send_matrix(0, COEF_MIN, COEF_MAX, 0, 12345, -6789);
		send_matrix(-one, -one, one, -one, '1, '0);
		send_matrix(32'sh7fff_0000, 32'sh1234_5678, -32'sh0abc_def0, 32'sh0000_0001,
			32'sh5555_5555, 32'shAAAA_AAAA);
		send_matrix(2, 1, 1, 2, COEF_MIN, 0);
	endtask

	// Random matrices, mixing well-conditioned ones with singular and extreme ones.
	task automatic test_random(input int count);
		coef_t a, b, c, d;
		repeat (count) begin
			a = random_coef(); b = random_coef(); c = random_coef(); d = random_coef();
			if ($urandom_range(0, 9) == 0) begin
				c = a; d = b;
			end
			send_matrix(a, b, c, d, random_coef(), random_coef());
		end
	endtask

	// Receiver stalls: a new random wait is drawn for every result.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 9);
			if ($urandom_range(0, 3) == 0)
				stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// Checks every result transaction against the oldest pending inverse.
	always @(posedge clk) begin
		inverse_t exp_inv;
		coef_t    got [6];
		string    names [6];
		if (arst_n && out_valid && out_ready) begin
			inverses_seen++;
			if (pending_inverses.size() == 0) begin
				$error("Result transaction with no matrix pending");
				mismatch_count++;
			end else begin
				exp_inv = pending_inverses.pop_front();
				got = '{inv_a, inv_b, inv_c, inv_d, inv_shift_x, inv_shift_y};
				names = '{"inv_a", "inv_b", "inv_c", "inv_d", "inv_shift_x", "inv_shift_y"};
				if (exp_inv.sing) singular_seen++;
				if (exp_inv.ovf) overflow_seen++;
				foreach (got[k])
					if (got[k] !== exp_inv.fld[k]) begin
						$error("%s expected %0d actual %0d", names[k], exp_inv.fld[k], got[k]);
						mismatch_count++;
					end
				if (singular !== exp_inv.sing) begin
					$error("singular expected %0b actual %0b", exp_inv.sing, singular);
					mismatch_count++;
				end
				if (overflow !== exp_inv.ovf) begin
					$error("overflow expected %0b actual %0b", exp_inv.ovf, overflow);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		mismatch_count = 0;
		matrices_sent = 0;
		inverses_seen = 0;
		singular_seen = 0;
		overflow_seen = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		coef_a = '0; coef_b = '0; coef_c = '0; coef_d = '0;
		shift_x = '0; shift_y = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1230);
		in_valid <= 1'b0;
		// Drain the pipeline, then give it the full latency to show any extra result.
		while (pending_inverses.size() != 0)
			@(posedge clk);
		repeat (2 * (QW + 6)) @(posedge clk);
		$display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated).",
			matrices_sent, inverses_seen, singular_seen, overflow_seen);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
